>>> rtl/toroidal_life_generation_engine_defines.svh
// Assertion macros shared by the toroidal life engine RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TLGE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLGE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tlge_pkg.sv
// Package for the toroidal life engine: field widths, grid defaults,
// command codes and sequencer states. No dependencies.
`default_nettype none

package tlge_pkg;

   localparam int CMD_W          = 2;
   localparam int ROW_FIELD_W    = 5;
   localparam int COL_FIELD_W    = 5;
   localparam int DEF_GRID_WIDTH  = 32;
   localparam int DEF_GRID_HEIGHT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_ADVANCE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_LAST,
      ST_LOAD_FIRST,
      ST_LOAD_SECOND,
      ST_ROW
   } state_type;

endpackage

`default_nettype wire

>>> rtl/toroidal_life_generation_engine.sv
// Toroidal Game of Life engine: grid memory, cell access pipeline and
// generation sequencer. Depends on tlge_pkg and the engine defines header.
//
// Usage:
//   Drive start with req_command, req_row, req_column and req_alive_in; the
//   beat is taken at a rising edge where start is high and busy is low.
//   Every beat gives exactly one result beat on rsp_alive_out/rsp_was_read,
//   shown for one cycle with rsp_valid high. The receiver cannot stall.
// Flow:
//   Write, read and the unused code stream at one beat per cycle while busy
//   is low; each beat is registered in the cell stage, then its result in the
//   result register. A write is a read-modify-write of one row word; a
//   back-to-back access of the same row is forwarded from the write in flight.
//   Advance raises busy: three load states prime the old last row, old row 0
//   and row 1, then one row per cycle is rebuilt in place, bounded by the
//   single read port of the grid memory. Its result comes on the edge that
//   writes the last row.
// Reset:
//   Synchronous, active high. A valid flop per row marks rows never written
//   since reset; such rows read as all dead, so no clearing pass is needed.
//   Results are dropped and the sequencer returns to idle.
`default_nettype none

module toroidal_life_generation_engine #(
   parameter int GRID_WIDTH  = tlge_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = tlge_pkg::DEF_GRID_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [tlge_pkg::CMD_W-1:0]       req_command,
   input  wire logic [tlge_pkg::ROW_FIELD_W-1:0] req_row,
   input  wire logic [tlge_pkg::COL_FIELD_W-1:0] req_column,
   input  wire logic                             req_alive_in,
   output logic                                  rsp_valid,
   output logic                                  rsp_alive_out,
   output logic                                  rsp_was_read
);

   `include "toroidal_life_generation_engine_defines.svh"

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int EXT_W = 7;
   localparam logic [EXT_W-1:0] HEIGHT_EXT = EXT_W'(GRID_HEIGHT);
   localparam logic [EXT_W-1:0] WIDTH_EXT  = EXT_W'(GRID_WIDTH);
   localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(GRID_HEIGHT - 1);

   typedef logic [GRID_WIDTH-1:0] row_word_type;

   // Next generation of one row from the old rows above, at and below it.
   function automatic row_word_type life_row(input row_word_type up,
                                             input row_word_type mid,
                                             input row_word_type dn);
      row_word_type res;
      int           l;
      int           r;
      logic [3:0]   n;
      res = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         l = (c == 0) ? GRID_WIDTH - 1 : c - 1;
         r = (c == GRID_WIDTH - 1) ? 0 : c + 1;
         n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
           + 4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
         res[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- storage
   row_word_type               grid_mem [GRID_HEIGHT];
   logic [GRID_HEIGHT-1:0]     row_valid_ff;

   tlge_pkg::state_type        state_ff, state_in;

   // Cell access stage
   logic                       s1_valid_ff;
   tlge_pkg::cmd_type          s1_cmd_ff;
   logic [ROW_W-1:0]           s1_addr_ff;
   logic [COL_W-1:0]           s1_col_ff;
   logic                       s1_inside_ff;
   logic                       s1_alive_ff;

   // Read port return path
   row_word_type               mem_q_ff;
   logic                       rd_valid_ff;
   logic                       rd_fwd_ff;
   row_word_type               fwd_data_ff;

   // Generation sequencer
   row_word_type               upper_ff;
   row_word_type               first_ff;
   row_word_type               cur_ff;
   logic [ROW_W-1:0]           y_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_alive_ff, rsp_alive_in;
   logic                       rsp_read_ff, rsp_read_in;

   // ---------------------------------------------------------------- decode
   logic                       accept;
   tlge_pkg::cmd_type          req_cmd;
   logic [EXT_W-1:0]           row_ext;
   logic [EXT_W-1:0]           col_ext;
   logic                       req_inside;
   logic [ROW_W-1:0]           req_addr;
   logic [COL_W-1:0]           req_col;
   logic                       req_is_cell;

   assign busy        = (state_ff != tlge_pkg::ST_IDLE);
   assign accept      = start && !busy;
   assign req_cmd     = tlge_pkg::cmd_type'(req_command);
   assign row_ext     = EXT_W'(req_row);
   assign col_ext     = EXT_W'(req_column);
   assign req_inside  = (row_ext < HEIGHT_EXT) && (col_ext < WIDTH_EXT);
   assign req_addr    = row_ext[ROW_W-1:0];
   assign req_col     = col_ext[COL_W-1:0];
   assign req_is_cell = (req_cmd == tlge_pkg::CMD_WRITE) || (req_cmd == tlge_pkg::CMD_READ);

   // Row word as seen by the stage after a read: forwarded, stored, or dead.
   row_word_type               row_eff;
   assign row_eff = rd_fwd_ff ? fwd_data_ff : (rd_valid_ff ? mem_q_ff : '0);

   // ---------------------------------------------------------------- cell stage
   logic                       s1_wr;
   row_word_type               s1_new_row;
   logic                       s1_cell;

   always_comb begin
      s1_new_row            = row_eff;
      s1_new_row[s1_col_ff] = s1_alive_ff;
      s1_cell               = s1_inside_ff ? row_eff[s1_col_ff] : 1'b0;
      s1_wr = s1_valid_ff && (s1_cmd_ff == tlge_pkg::CMD_WRITE) && s1_inside_ff;
   end

   // ---------------------------------------------------------------- sequencer
   logic [ROW_W:0]             y_ahead;
   row_word_type               below;
   row_word_type               adv_row;
   logic                       last_row;

   assign y_ahead  = {1'b0, y_ff} + (ROW_W + 1)'(2);
   assign last_row = (y_ff == LAST_ROW);
   assign below    = last_row ? first_ff : row_eff;
   assign adv_row  = life_row(upper_ff, cur_ff, below);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlge_pkg::ST_IDLE: begin
            if (accept && (req_cmd == tlge_pkg::CMD_ADVANCE)) begin
               state_in = tlge_pkg::ST_LOAD_LAST;
            end
         end
         tlge_pkg::ST_LOAD_LAST:   state_in = tlge_pkg::ST_LOAD_FIRST;
         tlge_pkg::ST_LOAD_FIRST:  state_in = tlge_pkg::ST_LOAD_SECOND;
         tlge_pkg::ST_LOAD_SECOND: state_in = tlge_pkg::ST_ROW;
         tlge_pkg::ST_ROW: begin
            if (last_row) begin
               state_in = tlge_pkg::ST_IDLE;
            end
         end
         default:                  state_in = tlge_pkg::ST_IDLE;
      endcase
   end

   // Memory port control
   logic                       rd_en;
   logic [ROW_W-1:0]           rd_addr;
   logic                       wr_en;
   logic [ROW_W-1:0]           wr_addr;
   row_word_type               wr_data;
   logic                       adv_done;

   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = req_addr;
      wr_en    = s1_wr;
      wr_addr  = s1_addr_ff;
      wr_data  = s1_new_row;
      adv_done = 1'b0;
      unique case (state_ff)
         tlge_pkg::ST_IDLE: begin
            rd_en = accept && req_is_cell && req_inside;
         end
         tlge_pkg::ST_LOAD_LAST: begin
            rd_en   = 1'b1;
            rd_addr = LAST_ROW;
         end
         tlge_pkg::ST_LOAD_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         tlge_pkg::ST_LOAD_SECOND: begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(1);
         end
         tlge_pkg::ST_ROW: begin
            rd_en    = (y_ahead < (ROW_W + 1)'(GRID_HEIGHT));
            rd_addr  = y_ahead[ROW_W-1:0];
            wr_en    = 1'b1;
            wr_addr  = y_ff;
            wr_data  = adv_row;
            adv_done = last_row;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= grid_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
         // Bypass a write landing on the same row at this edge.
         rd_fwd_ff   <= s1_wr && (s1_addr_ff == rd_addr);
         fwd_data_ff <= s1_new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tlge_pkg::ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= accept && (req_cmd != tlge_pkg::CMD_ADVANCE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_addr_ff   <= req_addr;
         s1_col_ff    <= req_col;
         s1_inside_ff <= req_inside;
         s1_alive_ff  <= req_alive_in;
      end
   end

   // Hold the old neighbor rows while rows are rewritten in place.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tlge_pkg::ST_LOAD_FIRST: begin
            upper_ff <= row_eff;
         end
         tlge_pkg::ST_LOAD_SECOND: begin
            first_ff <= row_eff;
            cur_ff   <= row_eff;
            y_ff     <= '0;
         end
         tlge_pkg::ST_ROW: begin
            upper_ff <= cur_ff;
            cur_ff   <= below;
            y_ff     <= y_ff + ROW_W'(1);
         end
         default: begin
            y_ff <= y_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = s1_valid_ff || adv_done;
      rsp_alive_in = 1'b0;
      rsp_read_in  = 1'b0;
      if (s1_valid_ff) begin
         case (s1_cmd_ff)
            tlge_pkg::CMD_READ: begin
               rsp_alive_in = s1_cell;
               rsp_read_in  = 1'b1;
            end
            default: begin
               rsp_alive_in = 1'b0;
               rsp_read_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_alive_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_alive_ff <= rsp_alive_in;
         rsp_read_ff  <= rsp_read_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alive_out = rsp_alive_ff;
   assign rsp_was_read  = rsp_read_ff;

   // ---------------------------------------------------------------- checks
   `TLGE_ASSERT_NEXT(a_cell_result, clock, reset, s1_valid_ff, rsp_valid, "cell beat lost its result")
   `TLGE_ASSERT_NOW(a_no_port_clash, clock, reset, state_ff == tlge_pkg::ST_ROW, !s1_valid_ff, "cell write overlaps generation sweep")
   `TLGE_ASSERT_NEXT(a_adv_result, clock, reset, adv_done, rsp_valid && !rsp_was_read && !rsp_alive_out, "advance result missing or not blank")
   `TLGE_ASSERT_NOW(a_alive_only_read, clock, reset, rsp_alive_out, rsp_valid && rsp_was_read, "live cell shown outside a read result")

endmodule

`default_nettype wire

>>> tb/sv/life_grid_checker.sv
// Checker for the toroidal life engine: watches the command and result beats,
// keeps its own copy of the grid and compares every result. Depends on tlge_pkg.
`default_nettype none

module life_grid_checker #(
   parameter int GRID_WIDTH  = tlge_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = tlge_pkg::DEF_GRID_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic [tlge_pkg::CMD_W-1:0]       req_command,
   input  wire logic [tlge_pkg::ROW_FIELD_W-1:0] req_row,
   input  wire logic [tlge_pkg::COL_FIELD_W-1:0] req_column,
   input  wire logic                             req_alive_in,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_alive_out,
   input  wire logic                             rsp_was_read,
   output int                                    mismatch_count,
   output int                                    replies_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [GRID_WIDTH-1:0] row_word_type;

   typedef struct packed {
      logic alive_out;
      logic was_read;
   } cell_reply_type;

   row_word_type   life_grid [GRID_HEIGHT];
   cell_reply_type pending_replies [$];
   int             fault_tally = 0;

   // One generation on the torus; every new cell looks only at the old grid.
   function automatic void rebuild_generation();
      row_word_type old_grid [GRID_HEIGHT];
      int           r, c, dr, dc, neighbours;
      logic         live;
      old_grid = life_grid;
      for (r = 0; r < GRID_HEIGHT; r++) begin
         for (c = 0; c < GRID_WIDTH; c++) begin
            neighbours = 0;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     neighbours += old_grid[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                                           [(c + dc + GRID_WIDTH) % GRID_WIDTH];
                  end
               end
            end
            live = old_grid[r][c];
            life_grid[r][c] = live ? (neighbours == 2 || neighbours == 3)
                                   : (neighbours == 3);
         end
      end
   endfunction

   function automatic cell_reply_type apply_command(
      input logic [tlge_pkg::CMD_W-1:0]       opcode,
      input logic [tlge_pkg::ROW_FIELD_W-1:0] row,
      input logic [tlge_pkg::COL_FIELD_W-1:0] column,
      input logic                             alive
   );
      cell_reply_type reply;
      logic           on_grid;
      reply   = '0;
      on_grid = (int'(row) < GRID_HEIGHT) && (int'(column) < GRID_WIDTH);
      case (opcode)
         tlge_pkg::CMD_WRITE: begin
            if (on_grid) life_grid[row][column] = alive;
         end
         tlge_pkg::CMD_READ: begin
            reply.was_read  = 1'b1;
            reply.alive_out = on_grid ? life_grid[row][column] : 1'b0;
         end
         tlge_pkg::CMD_ADVANCE: begin
            rebuild_generation();
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      cell_reply_type due;
      if (reset) begin
         foreach (life_grid[r]) life_grid[r] = '0;
         pending_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               $error("result beat with none expected: alive_out %0b, was_read %0b",
                      rsp_alive_out, rsp_was_read);
               fault_tally++;
            end else begin
               due = pending_replies.pop_front();
               if (rsp_alive_out !== due.alive_out) begin
                  $error("alive_out mismatch: expected %0b, actual %0b",
                         due.alive_out, rsp_alive_out);
                  fault_tally++;
               end
               if (rsp_was_read !== due.was_read) begin
                  $error("was_read mismatch: expected %0b, actual %0b",
                         due.was_read, rsp_was_read);
                  fault_tally++;
               end
            end
         end
         if (start && !busy) begin
            pending_replies.push_back(apply_command(req_command, req_row, req_column,
                                                    req_alive_in));
         end
      end
      mismatch_count      <= fault_tally;
      replies_outstanding <= pending_replies.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Top of the toroidal life engine testbench: clock, reset, command stimulus,
// watchdog and verdict. Depends on tlge_pkg, the engine RTL and life_grid_checker.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int H = tlge_pkg::DEF_GRID_HEIGHT;
   localparam int W = tlge_pkg::DEF_GRID_WIDTH;

   // The two-bit command field has one code the package leaves unnamed.
   localparam logic [tlge_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_BEATS   = 850;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             start        = 1'b0;
   logic [tlge_pkg::CMD_W-1:0]       req_command  = '0;
   logic [tlge_pkg::ROW_FIELD_W-1:0] req_row      = '0;
   logic [tlge_pkg::COL_FIELD_W-1:0] req_column   = '0;
   logic                             req_alive_in = 1'b0;
   logic                             busy;
   logic                             rsp_valid;
   logic                             rsp_alive_out;
   logic                             rsp_was_read;

   int mismatch_count;
   int replies_outstanding;
   int beats_sent  = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   toroidal_life_generation_engine dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_alive_in  (req_alive_in),
      .rsp_valid     (rsp_valid),
      .rsp_alive_out (rsp_alive_out),
      .rsp_was_read  (rsp_was_read)
   );

   life_grid_checker grid_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_row             (req_row),
      .req_column          (req_column),
      .req_alive_in        (req_alive_in),
      .rsp_valid           (rsp_valid),
      .rsp_alive_out       (rsp_alive_out),
      .rsp_was_read        (rsp_was_read),
      .mismatch_count      (mismatch_count),
      .replies_outstanding (replies_outstanding)
   );

   // Mostly back to back or short gaps, now and then a long pause; a calm
   // stretch keeps the command port saturated.
   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   // Present one command beat, hold it until an edge takes it with busy low,
   // then drop start for the gap. With no gap start stays high, so the next
   // beat follows in the very next cycle without a second assignment.
   task automatic drive_beat(
      input logic [tlge_pkg::CMD_W-1:0] opcode,
      input int                         row,
      input int                         column,
      input int                         alive,
      input int                         gap
   );
      start        <= 1'b1;
      req_command  <= opcode;
      req_row      <= row[tlge_pkg::ROW_FIELD_W-1:0];
      req_column   <= column[tlge_pkg::COL_FIELD_W-1:0];
      req_alive_in <= alive[0];
      do @(posedge clock); while (busy);
      if (opcode != CMD_UNUSED) beats_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Watchdog: count cycles in which neither a command nor a result beat
   // moves. A correct run never stalls longer than a long gap plus one advance.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("toroidal_life_generation_engine verification failed");
            $finish;
         end
      end
   end

   initial begin
      int                         random_base;
      int                         origin_row;
      int                         origin_col;
      int                         roll;
      bit                         calm;
      logic [tlge_pkg::CMD_W-1:0] opcode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- Directed part ---
      // Read a cell never written: the grid comes out of reset all dead.
      drive_beat(tlge_pkg::CMD_READ, 0, 0, 1, 0);

      // The four corners wrap into one 2x2 block, a still life on the torus.
      drive_beat(tlge_pkg::CMD_WRITE, 0,     0,     1, 0);
      drive_beat(tlge_pkg::CMD_WRITE, H - 1, W - 1, 1, 0);
      drive_beat(tlge_pkg::CMD_WRITE, 0,     W - 1, 1, 0);
      drive_beat(tlge_pkg::CMD_WRITE, H - 1, 0,     1, 0);
      // Read straight after a write of the same row exercises forwarding.
      drive_beat(tlge_pkg::CMD_READ, H - 1, 0, 0, 0);
      drive_beat(tlge_pkg::CMD_ADVANCE, 31, 31, 1, 0);
      drive_beat(tlge_pkg::CMD_READ, 0, 0, 0, 2);

      // The unused code must leave the grid alone, whatever its fields say.
      drive_beat(CMD_UNUSED, H - 1, W - 1, 0, 0);
      drive_beat(tlge_pkg::CMD_READ, H - 1, W - 1, 1, 0);

      // Kill the block again.
      drive_beat(tlge_pkg::CMD_WRITE, 0,     0,     0, 0);
      drive_beat(tlge_pkg::CMD_WRITE, H - 1, W - 1, 0, 0);
      drive_beat(tlge_pkg::CMD_WRITE, 0,     W - 1, 0, 1);
      drive_beat(tlge_pkg::CMD_WRITE, H - 1, 0,     0, 0);

      // Blinker straddling the column wrap; after one advance it stands
      // vertical, after two it lies flat again.
      drive_beat(tlge_pkg::CMD_WRITE, 15, W - 1, 1, 0);
      drive_beat(tlge_pkg::CMD_WRITE, 15, 0,     1, 0);
      drive_beat(tlge_pkg::CMD_WRITE, 15, 1,     1, 0);
      drive_beat(tlge_pkg::CMD_ADVANCE, 0, 0, 0, 0);
      drive_beat(tlge_pkg::CMD_READ, 14, 0,     0, 0);
      drive_beat(tlge_pkg::CMD_READ, 16, 0,     0, 0);
      drive_beat(tlge_pkg::CMD_READ, 15, W - 1, 0, 0);
      drive_beat(tlge_pkg::CMD_ADVANCE, 21, 10, 1, 3);
      drive_beat(tlge_pkg::CMD_READ, 15, W - 1, 1, 0);
      drive_beat(tlge_pkg::CMD_READ, 14, 0,     1, 0);

      // --- Random part ---
      // Mostly seed bursts: paint a small patch with random live cells,
      // advance a few generations and probe around the patch, so that real
      // patterns grow, collide and wrap. The rest is loose noise, the unused
      // code among it.
      random_base = beats_sent;
      while (beats_sent - random_base < RANDOM_BEATS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            origin_row = $urandom_range(0, H - 1);
            origin_col = $urandom_range(0, W - 1);
            repeat ($urandom_range(4, 12)) begin
               drive_beat(tlge_pkg::CMD_WRITE, (origin_row + $urandom_range(0, 3)) % H,
                          (origin_col + $urandom_range(0, 3)) % W,
                          int'($urandom_range(0, 3) != 0), pick_gap(calm));
            end
            repeat ($urandom_range(1, 3)) begin
               drive_beat(tlge_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom,
                          pick_gap(calm));
            end
            repeat ($urandom_range(3, 8)) begin
               drive_beat(tlge_pkg::CMD_READ,
                          (origin_row + H - 1 + $urandom_range(0, 5)) % H,
                          (origin_col + W - 1 + $urandom_range(0, 5)) % W,
                          $urandom, pick_gap(calm));
            end
         end else begin
            repeat (8) begin
               roll = $urandom_range(0, 99);
               if (roll < 45)      opcode = tlge_pkg::CMD_WRITE;
               else if (roll < 85) opcode = tlge_pkg::CMD_READ;
               else if (roll < 93) opcode = tlge_pkg::CMD_ADVANCE;
               else                opcode = CMD_UNUSED;
               drive_beat(opcode, $urandom, $urandom, $urandom, pick_gap(calm));
            end
         end
      end
      start <= 1'b0;

      // --- Drain ---
      // Let the last accepted beat reach the checker, wait out every result,
      // then watch a little longer than one advance for stray beats.
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (H + 8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("toroidal_life_generation_engine verification clean");
      end else begin
         $display("toroidal_life_generation_engine verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> toroidal_life_generation_engine.f
+incdir+rtl
rtl/tlge_pkg.sv
rtl/toroidal_life_generation_engine.sv
tb/sv/life_grid_checker.sv
tb/sv/testbench.sv
